/* rtl/wsts_pkg.sv */
`timescale 1ns / 1ps
package wsts_pkg;

	localparam int NUM_WORKERS = 4;
	localparam int WORKER_W = $clog2(NUM_WORKERS);
	localparam int TASK_WIDTH = 16;
	localparam int START_W = 2;
	localparam int CFG_W = 3;
	localparam int DEQUE_DEPTH_DEF = 64;
	localparam int INJECT_DEPTH_DEF = 64;
	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(4);

	typedef enum logic [1:0] {
		KIND_PUSH   = 2'd0,
		KIND_INJECT = 2'd1,
		KIND_FETCH  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SRC_OWN    = 2'd0,
		SRC_STEAL  = 2'd1,
		SRC_INJECT = 2'd2,
		SRC_NONE   = 2'd3
	} source_t;

	typedef struct packed {
		kind_t                 kind;
		logic [WORKER_W-1:0]   worker;
		logic [TASK_WIDTH-1:0] task_id;
		logic [START_W-1:0]    steal_start;
	} item_t;

	typedef struct packed {
		logic                found;
		source_t             source;
		logic [WORKER_W-1:0] victim;
		logic                accepted;
		logic                none_pending;
		logic                rd_deque;
		logic                rd_inject;
	} res_t;

endpackage

/* rtl/wsts_ram.sv */
`timescale 1ns / 1ps
module wsts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/wsts_ctrl.sv */
`timescale 1ns / 1ps
module wsts_ctrl import wsts_pkg::*; #(
	parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
	parameter int INJECT_DEPTH = INJECT_DEPTH_DEF,
	localparam int SLOT_W = $clog2(DEQUE_DEPTH),
	localparam int DQ_AW = WORKER_W + SLOT_W,
	localparam int IW = $clog2(INJECT_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  item_t             item,
	input  logic [CFG_W-1:0]  active_workers,
	output res_t              res,
	output logic              dq_we,
	output logic              dq_re,
	output logic [DQ_AW-1:0]  dq_addr,
	output logic              inj_we,
	output logic              inj_re,
	output logic [IW-1:0]     inj_addr
);

	localparam int PTR_W = $clog2(2 * DEQUE_DEPTH);
	localparam int CW = $clog2(INJECT_DEPTH + 1);

	logic [PTR_W-1:0] top_q [NUM_WORKERS];
	logic [PTR_W-1:0] bot_q [NUM_WORKERS];
	logic [PTR_W-1:0] top_d [NUM_WORKERS];
	logic [PTR_W-1:0] bot_d [NUM_WORKERS];
	logic [IW-1:0]    head_q, head_d, tail_q, tail_d;
	logic [CW-1:0]    count_q, count_d;

	logic [NUM_WORKERS-1:0] nonempty, full;
	logic [CFG_W-1:0]       n, peers, p, q;
	logic [WORKER_W-1:0]    v, vic;
	logic                   self_ok, hit;
	logic [PTR_W-1:0]       ptr;
	logic                   empty_all;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] x);
		return (x == PTR_W'(2 * DEQUE_DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] x);
		return (x == '0) ? PTR_W'(2 * DEQUE_DEPTH - 1) : x - 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] x);
		logic [PTR_W-1:0] s;
		s = (x >= PTR_W'(DEQUE_DEPTH)) ? x - PTR_W'(DEQUE_DEPTH) : x;
		return s[SLOT_W-1:0];
	endfunction

	// Fill level is bottom minus top modulo twice the depth.
	always_comb begin
		logic [PTR_W:0] diff;
		for (int w = 0; w < NUM_WORKERS; w++) begin
			diff = (bot_q[w] >= top_q[w])
				? {1'b0, bot_q[w]} - {1'b0, top_q[w]}
				: {1'b0, bot_q[w]} + (PTR_W+1)'(2 * DEQUE_DEPTH) - {1'b0, top_q[w]};
			nonempty[w] = (top_q[w] != bot_q[w]);
			full[w] = (diff == (PTR_W+1)'(DEQUE_DEPTH));
		end
	end

	always_comb begin
		if (active_workers == '0) begin
			n = CFG_W'(1);
		end else if (active_workers > CFG_W'(NUM_WORKERS)) begin
			n = CFG_W'(NUM_WORKERS);
		end else begin
			n = active_workers;
		end
		peers = n - 1'b1;
		self_ok = ({1'b0, item.worker} < n);

		// Start offset modulo the peer count; the start value is small.
		q = CFG_W'(item.steal_start);
		for (int k = 0; k < (1 << START_W) - 1; k++) begin
			if (peers != '0 && q >= peers) begin
				q = q - peers;
			end
		end

		p = q;
		hit = 1'b0;
		vic = '0;
		v = '0;
		for (int i = 0; i < NUM_WORKERS - 1; i++) begin
			if (CFG_W'(i) < peers && !hit) begin
				v = (p < {1'b0, item.worker}) ? p[WORKER_W-1:0] : WORKER_W'(p + 1'b1);
				if (nonempty[v]) begin
					hit = 1'b1;
					vic = v;
				end
				p = (p + 1'b1 >= peers) ? '0 : p + 1'b1;
			end
		end
	end

	always_comb begin
		top_d = top_q;
		bot_d = bot_q;
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		res = '0;
		res.source = SRC_NONE;
		dq_we = 1'b0;
		dq_re = 1'b0;
		dq_addr = '0;
		inj_we = 1'b0;
		inj_re = 1'b0;
		inj_addr = '0;
		ptr = '0;
		unique case (item.kind)
			KIND_PUSH: begin
				if (self_ok && !full[item.worker]) begin
					ptr = bot_q[item.worker];
					dq_we = 1'b1;
					dq_addr = {item.worker, ptr_slot(ptr)};
					bot_d[item.worker] = ptr_inc(ptr);
					res.accepted = 1'b1;
				end
			end
			KIND_INJECT: begin
				if (count_q != CW'(INJECT_DEPTH)) begin
					inj_we = 1'b1;
					inj_addr = tail_q;
					tail_d = (tail_q == IW'(INJECT_DEPTH - 1)) ? '0 : tail_q + 1'b1;
					count_d = count_q + 1'b1;
					res.accepted = 1'b1;
				end
			end
			KIND_FETCH: begin
				if (self_ok) begin
					if (nonempty[item.worker]) begin
						ptr = ptr_dec(bot_q[item.worker]);
						bot_d[item.worker] = ptr;
						dq_re = 1'b1;
						dq_addr = {item.worker, ptr_slot(ptr)};
						res.found = 1'b1;
						res.source = SRC_OWN;
						res.rd_deque = 1'b1;
					end else if (hit) begin
						ptr = top_q[vic];
						top_d[vic] = ptr_inc(ptr);
						dq_re = 1'b1;
						dq_addr = {vic, ptr_slot(ptr)};
						res.found = 1'b1;
						res.source = SRC_STEAL;
						res.victim = vic;
						res.rd_deque = 1'b1;
					end else if (count_q != '0) begin
						inj_re = 1'b1;
						inj_addr = head_q;
						head_d = (head_q == IW'(INJECT_DEPTH - 1)) ? '0 : head_q + 1'b1;
						count_d = count_q - 1'b1;
						res.found = 1'b1;
						res.source = SRC_INJECT;
						res.rd_inject = 1'b1;
					end
				end
			end
			KIND_NONE: begin
			end
			default: begin
			end
		endcase

		empty_all = (count_d == '0);
		for (int w = 0; w < NUM_WORKERS; w++) begin
			if (top_d[w] != bot_d[w]) begin
				empty_all = 1'b0;
			end
		end
		res.none_pending = empty_all;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NUM_WORKERS; w++) begin
				top_q[w] <= '0;
				bot_q[w] <= '0;
			end
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (fire) begin
			top_q <= top_d;
			bot_q <= bot_d;
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
		end
	end

endmodule

/* rtl/work_stealing_task_scheduler.sv */
`timescale 1ns / 1ps
// Channel   Signals                                          Direction
// in        in_valid, in_ready, kind, worker, task_id,       input beat
//           steal_start
// out       out_valid, out_ready, task_found, task_out,      output beat
//           source, victim, push_accepted, none_pending
// cfg       cfg_we, cfg_data (active_workers)                write only
//
// Each item sits in the input register, where the pointer update and the task
// RAM access happen, and then in the result register while the RAM read data
// is returned. One item can be accepted every cycle while the output is not
// stalled. A stalled output holds the result register and the RAM read data,
// and the input register then fills and drops in_ready. Reset empties every
// deque and the injection queue and sets active_workers to 4.
module work_stealing_task_scheduler import wsts_pkg::*; #(
	parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
	parameter int INJECT_DEPTH = INJECT_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [WORKER_W-1:0]   worker,
	input  logic [TASK_WIDTH-1:0] task_id,
	input  logic [START_W-1:0]    steal_start,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  task_found,
	output logic [TASK_WIDTH-1:0] task_out,
	output logic [1:0]            source,
	output logic [WORKER_W-1:0]   victim,
	output logic                  push_accepted,
	output logic                  none_pending,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int SLOT_W = $clog2(DEQUE_DEPTH);
	localparam int DQ_AW = WORKER_W + SLOT_W;
	localparam int IW = $clog2(INJECT_DEPTH);

	logic [CFG_W-1:0] active_workers_q;
	item_t            item_s1;
	logic             valid_s1, valid_s2;
	res_t             res, res_s2;
	logic             adv;

	logic                  dq_we, dq_re, inj_we, inj_re;
	logic [DQ_AW-1:0]      dq_addr;
	logic [IW-1:0]         inj_addr;
	logic [TASK_WIDTH-1:0] dq_rdata, inj_rdata;

	assign adv = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_workers_q <= ACTIVE_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_workers_q <= cfg_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{kind: kind_t'(kind), worker: worker, task_id: task_id,
				steal_start: steal_start};
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	wsts_ctrl #(
		.DEQUE_DEPTH(DEQUE_DEPTH),
		.INJECT_DEPTH(INJECT_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.fire(adv),
		.item(item_s1),
		.active_workers(active_workers_q),
		.res(res),
		.dq_we(dq_we),
		.dq_re(dq_re),
		.dq_addr(dq_addr),
		.inj_we(inj_we),
		.inj_re(inj_re),
		.inj_addr(inj_addr)
	);

	// RAM reads are issued only when the item moves on, so the read data
	// stays put while the result waits for out_ready.
	wsts_ram #(
		.WIDTH(TASK_WIDTH),
		.DEPTH(NUM_WORKERS << SLOT_W)
	) u_deque_ram (
		.clk(clk),
		.we(dq_we && adv),
		.waddr(dq_addr),
		.wdata(item_s1.task_id),
		.re(dq_re && adv),
		.raddr(dq_addr),
		.rdata(dq_rdata)
	);

	wsts_ram #(
		.WIDTH(TASK_WIDTH),
		.DEPTH(INJECT_DEPTH)
	) u_inject_ram (
		.clk(clk),
		.we(inj_we && adv),
		.waddr(inj_addr),
		.wdata(item_s1.task_id),
		.re(inj_re && adv),
		.raddr(inj_addr),
		.rdata(inj_rdata)
	);

	assign out_valid = valid_s2;
	assign task_found = res_s2.found;
	assign task_out = res_s2.rd_deque ? dq_rdata : (res_s2.rd_inject ? inj_rdata : '0);
	assign source = res_s2.source;
	assign victim = res_s2.victim;
	assign push_accepted = res_s2.accepted;
	assign none_pending = res_s2.none_pending;

endmodule

/* verif/tb_work_stealing_task_scheduler.sv */
`timescale 1ns / 1ps
module tb_work_stealing_task_scheduler;
	import wsts_pkg::*;

	localparam int DQ_DEPTH = DEQUE_DEPTH_DEF;
	localparam int INJ_DEPTH = INJECT_DEPTH_DEF;
	localparam int PTR_SPAN = 2 * DQ_DEPTH;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 128;

	typedef struct {
		logic                  found;
		logic [TASK_WIDTH-1:0] task_val;
		source_t               src;
		logic [WORKER_W-1:0]   vic;
		logic                  acc;
		logic                  empty;
	} sched_outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            kind;
	logic [WORKER_W-1:0]   worker;
	logic [TASK_WIDTH-1:0] task_id;
	logic [START_W-1:0]    steal_start;
	logic                  out_valid;
	logic                  out_ready;
	logic                  task_found;
	logic [TASK_WIDTH-1:0] task_out;
	logic [1:0]            source;
	logic [WORKER_W-1:0]   victim;
	logic                  push_accepted;
	logic                  none_pending;
	logic                  cfg_we;
	logic [CFG_W-1:0]      cfg_data;

	// Scheduler state as the testbench expects it.
	logic [TASK_WIDTH-1:0] dq_mem [NUM_WORKERS][DQ_DEPTH];
	int                    dq_top [NUM_WORKERS];
	int                    dq_bot [NUM_WORKERS];
	logic [TASK_WIDTH-1:0] inj_mem [INJ_DEPTH];
	int                    inj_head;
	int                    inj_tail;
	int                    inj_count;
	logic [CFG_W-1:0]      active_reg;

	sched_outcome_t outcome_q [$];
	int             mismatches = 0;
	int             quiet_cycles = 0;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;

	logic [CFG_W-1:0] phase_cfg [8] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6};
	int               phase_send [4] = '{0, 51, 0, 14};
	int               phase_recv [4] = '{0, 0, 51, 14};

	work_stealing_task_scheduler uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.worker        (worker),
		.task_id       (task_id),
		.steal_start   (steal_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.task_found    (task_found),
		.task_out      (task_out),
		.source        (source),
		.victim        (victim),
		.push_accepted (push_accepted),
		.none_pending  (none_pending),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int active_count();
		int n;
		n = active_reg;
		if (n < 1) n = 1;
		if (n > NUM_WORKERS) n = NUM_WORKERS;
		return n;
	endfunction

	function automatic int dq_fill(int w);
		return (dq_bot[w] - dq_top[w] + PTR_SPAN) % PTR_SPAN;
	endfunction

	task automatic scheduler_reset();
		for (int w = 0; w < NUM_WORKERS; w++) begin
			dq_top[w] = 0;
			dq_bot[w] = 0;
		end
		inj_head = 0;
		inj_tail = 0;
		inj_count = 0;
		active_reg = ACTIVE_RESET;
	endtask

	// Apply one accepted request to the expected state and queue its outcome.
	task automatic schedule_request(input kind_t k, input logic [WORKER_W-1:0] w,
			input logic [TASK_WIDTH-1:0] t, input logic [START_W-1:0] s);
		sched_outcome_t r;
		int n, me, peers, p, v, i;
		r.found = 1'b0;
		r.task_val = '0;
		r.src = SRC_NONE;
		r.vic = '0;
		r.acc = 1'b0;
		n = active_count();
		me = w;
		case (k)
			KIND_PUSH: begin
				if (me < n && dq_fill(me) < DQ_DEPTH) begin
					dq_mem[me][dq_bot[me] % DQ_DEPTH] = t;
					dq_bot[me] = (dq_bot[me] + 1) % PTR_SPAN;
					r.acc = 1'b1;
				end
			end
			KIND_INJECT: begin
				if (inj_count < INJ_DEPTH) begin
					inj_mem[inj_tail] = t;
					inj_tail = (inj_tail + 1) % INJ_DEPTH;
					inj_count++;
					r.acc = 1'b1;
				end
			end
			KIND_FETCH: begin
				if (me < n) begin
					if (dq_fill(me) != 0) begin
						dq_bot[me] = (dq_bot[me] + PTR_SPAN - 1) % PTR_SPAN;
						r.task_val = dq_mem[me][dq_bot[me] % DQ_DEPTH];
						r.found = 1'b1;
						r.src = SRC_OWN;
					end else begin
						if (n > 1) begin
							peers = n - 1;
							p = s % peers;
							for (i = 0; i < peers && !r.found; i++) begin
								// Peer numbers skip the requesting worker.
								v = (p < me) ? p : p + 1;
								if (dq_fill(v) != 0) begin
									r.task_val = dq_mem[v][dq_top[v] % DQ_DEPTH];
									dq_top[v] = (dq_top[v] + 1) % PTR_SPAN;
									r.found = 1'b1;
									r.src = SRC_STEAL;
									r.vic = WORKER_W'(v);
								end
								p = (p + 1) % peers;
							end
						end
						if (!r.found && inj_count != 0) begin
							r.task_val = inj_mem[inj_head];
							inj_head = (inj_head + 1) % INJ_DEPTH;
							inj_count--;
							r.found = 1'b1;
							r.src = SRC_INJECT;
						end
					end
				end
			end
			default: ;
		endcase
		r.empty = (inj_count == 0);
		for (i = 0; i < NUM_WORKERS; i++)
			if (dq_fill(i) != 0) r.empty = 1'b0;
		outcome_q.push_back(r);
	endtask

	task automatic send_item(input kind_t k, input logic [WORKER_W-1:0] w,
			input logic [TASK_WIDTH-1:0] t, input logic [START_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		worker <= w;
		task_id <= t;
		steal_start <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		schedule_request(k, w, t, s);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_active(input logic [CFG_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		active_reg = value;
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd0);
		send_item(KIND_PUSH, 2'd0, 16'h0000, 2'd0);
		send_item(KIND_PUSH, 2'd0, 16'hFFFF, 2'd3);
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd0);
		send_item(KIND_FETCH, 2'd1, 16'hFFFF, 2'd0);
		send_item(KIND_PUSH, 2'd2, 16'hA5A5, 2'd1);
		send_item(KIND_PUSH, 2'd3, 16'h5A5A, 2'd2);
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd2);
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd3);
		send_item(KIND_INJECT, 2'd3, 16'h1234, 2'd0);
		send_item(KIND_INJECT, 2'd0, 16'hFFFF, 2'd0);
		send_item(KIND_FETCH, 2'd1, 16'h0000, 2'd1);
		send_item(KIND_FETCH, 2'd3, 16'hFFFF, 2'd3);
		send_item(KIND_NONE, 2'd3, 16'hFFFF, 2'd3);
		send_item(KIND_PUSH, 2'd1, 16'h0001, 2'd0);
		send_item(KIND_INJECT, 2'd2, 16'h8000, 2'd0);
		send_item(KIND_NONE, 2'd0, 16'h0000, 2'd0);
		send_item(KIND_FETCH, 2'd1, 16'h0000, 2'd0);
		send_item(KIND_FETCH, 2'd2, 16'h0000, 2'd1);
		send_item(KIND_FETCH, 2'd3, 16'h0000, 2'd2);
	endtask

	task automatic test_inactive_workers();
		set_idling(14, 14);
		send_item(KIND_PUSH, 2'd2, 16'h0BAD, 2'd0);
		write_active(3'd2);
		send_item(KIND_PUSH, 2'd3, 16'h7777, 2'd0);
		send_item(KIND_FETCH, 2'd3, 16'h0000, 2'd0);
		// Worker 2 is inactive, so its task is out of reach but not empty.
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd1);
		send_item(KIND_PUSH, 2'd1, 16'h4321, 2'd0);
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd2);
		write_active(3'd1);
		send_item(KIND_PUSH, 2'd1, 16'h1111, 2'd0);
		send_item(KIND_PUSH, 2'd0, 16'h0F0F, 2'd0);
		send_item(KIND_FETCH, 2'd1, 16'h0000, 2'd0);
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd3);
		send_item(KIND_INJECT, 2'd1, 16'h2222, 2'd0);
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd3);
		write_active(3'd0);
		send_item(KIND_FETCH, 2'd0, 16'h0000, 2'd1);
		send_item(KIND_PUSH, 2'd1, 16'h3333, 2'd0);
		write_active(3'd7);
		send_item(KIND_FETCH, 2'd3, 16'h0000, 2'd0);
		write_active(ACTIVE_RESET);
	endtask

	// Fill one deque and the injection queue past capacity, then drain both.
	task automatic test_full_stores();
		int i;
		set_idling(14, 14);
		for (i = 0; i < DQ_DEPTH + 1; i++)
			send_item(KIND_PUSH, 2'd1, TASK_WIDTH'($urandom),
				START_W'($urandom_range(3)));
		for (i = 0; i < INJ_DEPTH + 1; i++)
			send_item(KIND_INJECT, WORKER_W'($urandom_range(3)), TASK_WIDTH'($urandom),
				START_W'($urandom_range(3)));
		for (i = 0; i < DQ_DEPTH + INJ_DEPTH + 2; i++)
			send_item(KIND_FETCH, 2'd1, TASK_WIDTH'($urandom),
				START_W'($urandom_range(3)));
	endtask

	task automatic test_random_mix(input int count);
		int i, r, push_pct, n;
		kind_t k;
		logic [WORKER_W-1:0] w;
		push_pct = 40;
		for (i = 0; i < count; i++) begin
			// Shift between filling and draining phases every few dozen beats.
			if (i % 40 == 0) push_pct = 20 * $urandom_range(1, 3);
			r = $urandom_range(99);
			if (r < push_pct) k = KIND_PUSH;
			else if (r < push_pct + 12) k = KIND_INJECT;
			else if (r < 97) k = KIND_FETCH;
			else k = KIND_NONE;
			n = active_count();
			if ($urandom_range(99) < 90) w = WORKER_W'($urandom_range(n - 1));
			else w = WORKER_W'($urandom_range(NUM_WORKERS - 1));
			send_item(k, w, TASK_WIDTH'($urandom), START_W'($urandom_range(3)));
		end
	endtask

	task automatic check_field(input string name, input logic [TASK_WIDTH-1:0] want,
			input logic [TASK_WIDTH-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : result_check
		sched_outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				$error("result beat with no request outstanding");
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				check_field("task_found", TASK_WIDTH'(want.found), TASK_WIDTH'(task_found));
				check_field("task_out", want.task_val, task_out);
				check_field("source", TASK_WIDTH'(want.src), TASK_WIDTH'(source));
				check_field("victim", TASK_WIDTH'(want.vic), TASK_WIDTH'(victim));
				check_field("push_accepted", TASK_WIDTH'(want.acc),
					TASK_WIDTH'(push_accepted));
				check_field("none_pending", TASK_WIDTH'(want.empty),
					TASK_WIDTH'(none_pending));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_NONE;
		worker <= '0;
		task_id <= '0;
		steal_start <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= ACTIVE_RESET;
		scheduler_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_inactive_workers();
		test_full_stores();
		for (ph = 0; ph < 8; ph++) begin
			write_active(phase_cfg[ph]);
			set_idling(phase_send[ph % 4], phase_recv[ph % 4]);
			test_random_mix(RANDOM_ITEMS);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

/* work_stealing_task_scheduler.f */
rtl/wsts_pkg.sv
rtl/wsts_ram.sv
rtl/wsts_ctrl.sv
rtl/work_stealing_task_scheduler.sv
verif/tb_work_stealing_task_scheduler.sv
